### rtl/opfl_pkg.sv
// ----------------------------------------------------------------------------
// opfl_pkg
// Shared constants, codes and types for the object pool free-list allocator.
// ----------------------------------------------------------------------------
package opfl_pkg;

  // Pool geometry
  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot index width
  localparam int PTR_W  = $clog2(SLOTS + 1);                // index or null
  localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

  // Fixed field widths
  localparam int GSLOT_W = 4;
  localparam int RECL_W  = 5;
  localparam int CFG_W   = 10;
  localparam int CIDX_W  = 2;

  // Item kinds
  localparam logic [1:0] KIND_SPAWN  = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_SWEEP  = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_OBJ_W   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_OBJ_H   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_FIELD_H = 2'd2;
  localparam logic [CIDX_W-1:0] REG_VIEW_W  = 2'd3;

  // Configuration reset values
  localparam logic [7:0] RST_OBJ_W   = 8'd16;
  localparam logic [7:0] RST_OBJ_H   = 8'd16;
  localparam logic [9:0] RST_FIELD_H = 10'd200;
  localparam logic [9:0] RST_VIEW_W  = 10'd320;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_FINISH
  } opfl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_in;     // capture the input item
    logic op_exec;     // run spawn / report / no-op and load the result
    logic sweep_init;  // start a walk of the active list
    logic sweep_step;  // process one active-list node
    logic sweep_out;   // load the sweep result
  } opfl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_sweep;    // captured item is a sweep
    logic cur_nil;     // sweep walk reached the end of the list
  } opfl_sts_t;

endpackage

### rtl/opfl_dp.sv
// ----------------------------------------------------------------------------
// opfl_dp
// Datapath: link table, liveness flags, list heads, cull compare, config and
// result registers.
// ----------------------------------------------------------------------------
module opfl_dp import opfl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  opfl_cmd_t           cmd,
  output opfl_sts_t           sts,
  input  logic [1:0]          kind,
  input  logic [3:0]          slot,
  input  logic signed [31:0]  x_pos,
  input  logic signed [31:0]  y_pos,
  input  logic [14:0]         view_left,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic [GSLOT_W-1:0]  granted_slot,
  output logic                granted,
  output logic                visible,
  output logic                retired,
  output logic [RECL_W-1:0]   reclaimed
);

  // captured item
  logic [1:0]         kind_q;
  logic [3:0]         slot_q;
  logic [31:0]        x_q;
  logic [15:0]        y_q;
  logic [14:0]        left_q;

  // config
  logic [7:0]         obj_w;
  logic [7:0]         obj_h;
  logic [9:0]         field_h;
  logic [9:0]         view_w;

  // pool state
  logic [PTR_W-1:0]   link_next [SLOTS];
  logic [SLOTS-1:0]   alive;
  logic [SLOTS-1:0]   seen_once;
  logic [PTR_W-1:0]   free_head;
  logic [PTR_W-1:0]   active_head;

  // sweep walk
  logic [PTR_W-1:0]   cur;
  logic [PTR_W-1:0]   prev;
  logic [PTR_W-1:0]   count;

  logic [SLOT_W-1:0]  fh_idx;
  logic [SLOT_W-1:0]  cur_idx;
  logic [SLOT_W-1:0]  prev_idx;
  logic [SLOT_W-1:0]  rpt_idx;
  logic [PTR_W-1:0]   nxt;
  logic               pool_empty;
  logic               rpt_ok;
  logic               outside;

  logic signed [17:0] xi;
  logic signed [17:0] yi;
  logic signed [17:0] lim_top;
  logic signed [17:0] lim_bot;
  logic signed [17:0] lim_lo;
  logic signed [17:0] lim_hi;

  assign fh_idx     = free_head[SLOT_W-1:0];
  assign cur_idx    = cur[SLOT_W-1:0];
  assign prev_idx   = prev[SLOT_W-1:0];
  assign rpt_idx    = SLOT_W'(slot_q);
  assign nxt        = link_next[cur_idx];
  assign pool_empty = (free_head == NIL);
  assign rpt_ok     = (32'(slot_q) < 32'(SLOTS)) && alive[rpt_idx];

  // Bounds are whole pixels, so compare integer parts; the right edge also
  // needs the fraction (strictly greater than the edge).
  assign xi      = 18'(signed'(x_q[31:16]));
  assign yi      = 18'(signed'(y_q));
  assign lim_top = -$signed({10'd0, obj_h});
  assign lim_bot = $signed({8'd0, field_h});
  assign lim_lo  = $signed({3'd0, left_q}) - $signed({10'd0, obj_w});
  assign lim_hi  = $signed({3'd0, left_q}) + $signed({8'd0, view_w});
  assign outside = (yi < lim_top) || (yi >= lim_bot) || (xi < lim_lo) ||
                   (xi > lim_hi) || ((xi == lim_hi) && (x_q[15:0] != 16'd0));

  assign sts.is_sweep = (kind_q == KIND_SWEEP);
  assign sts.cur_nil  = (cur == NIL);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_q <= kind;
      slot_q <= slot;
      x_q    <= x_pos;
      y_q    <= y_pos[31:16];
      left_q <= view_left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obj_w   <= RST_OBJ_W;
      obj_h   <= RST_OBJ_H;
      field_h <= RST_FIELD_H;
      view_w  <= RST_VIEW_W;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OBJ_W:   obj_w   <= cfg_data[7:0];
        REG_OBJ_H:   obj_h   <= cfg_data[7:0];
        REG_FIELD_H: field_h <= cfg_data;
        REG_VIEW_W:  view_w  <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Pool lists and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        link_next[i] <= PTR_W'(i + 1);
      end
      alive       <= '0;
      seen_once   <= '0;
      free_head   <= '0;
      active_head <= NIL;
    end else if (cmd.op_exec) begin
      if (kind_q == KIND_SPAWN && !pool_empty) begin
        free_head         <= link_next[fh_idx];
        link_next[fh_idx] <= active_head;
        active_head       <= free_head;
        alive[fh_idx]     <= 1'b1;
        seen_once[fh_idx] <= 1'b0;
      end else if (kind_q == KIND_REPORT && rpt_ok) begin
        if (outside) begin
          if (seen_once[rpt_idx]) alive[rpt_idx] <= 1'b0;
        end else begin
          seen_once[rpt_idx] <= 1'b1;
        end
      end
    end else if (cmd.sweep_step && !alive[cur_idx]) begin
      // unlink dead node and push it on the free head
      if (prev != NIL) link_next[prev_idx] <= nxt;
      else             active_head         <= nxt;
      link_next[cur_idx] <= free_head;
      free_head          <= cur;
    end
  end

  // Sweep walk registers
  always_ff @(posedge clk) begin
    if (cmd.sweep_init) begin
      cur   <= active_head;
      prev  <= NIL;
      count <= '0;
    end else if (cmd.sweep_step) begin
      cur <= nxt;
      if (alive[cur_idx]) prev  <= cur;
      else                count <= count + PTR_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.op_exec) begin
      granted_slot <= '0;
      granted      <= 1'b0;
      visible      <= 1'b0;
      retired      <= 1'b0;
      reclaimed    <= '0;
      if (kind_q == KIND_SPAWN && !pool_empty) begin
        granted_slot <= GSLOT_W'(free_head);
        granted      <= 1'b1;
      end else if (kind_q == KIND_REPORT && rpt_ok) begin
        visible <= !outside;
        retired <= outside && seen_once[rpt_idx];
      end
    end else if (cmd.sweep_out) begin
      granted_slot <= '0;
      granted      <= 1'b0;
      visible      <= 1'b0;
      retired      <= 1'b0;
      reclaimed    <= RECL_W'(count);
    end
  end

endmodule

### rtl/opfl_ctrl.sv
// ----------------------------------------------------------------------------
// opfl_ctrl
// Controller: sequences one item at a time and owns the handshake flags.
// ----------------------------------------------------------------------------
module opfl_ctrl import opfl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  opfl_sts_t sts,
  output opfl_cmd_t cmd
);

  opfl_state_t state;
  opfl_state_t state_next;
  logic        out_free;
  logic        out_load;
  logic        out_valid_next;

  assign out_free       = !out_valid || out_ready;
  assign out_load       = cmd.op_exec || cmd.sweep_out;
  assign out_valid_next = out_load || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        priority if (sts.is_sweep) begin
          cmd.sweep_init = 1'b1;
          state_next     = ST_SWEEP;
        end else if (out_free) begin
          cmd.op_exec = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          // output register still holds the previous result
          state_next = ST_EXEC;
        end
      end
      ST_SWEEP: begin
        if (sts.cur_nil) state_next = ST_FINISH;
        else             cmd.sweep_step = 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.sweep_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### rtl/object_pool_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// object_pool_free_list_allocator_top
// Fixed pool of object slots on index-linked free and active lists, with
// spawn, position-report culling and dead-slot sweep.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  in       | in_valid / in_ready  | kind, slot, x_pos, y_pos, view_left
//  out      | out_valid/ out_ready | granted_slot, granted, visible,
//           |                      | retired, reclaimed
//  cfg      | cfg_we (no wait)     | cfg_index, cfg_data
//
// Spawn, report and unused kinds: captured in the idle state, then executed in
// the exec state, which loads the result register and sets out_valid.
// Sweep: captured in the idle state, walk started in the exec state, then
// the sweep state walks the active list, one node per cycle through the single
// link-table read port of the walk, and the finish state loads the result.
// in_ready is high in the idle state, also while a result still waits on out.
// A stalled out holds the result; a finished item waits until out frees up.
// Synchronous reset puts the pool in its initial chain.
// ----------------------------------------------------------------------------
module object_pool_free_list_allocator_top import opfl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          kind,
  input  logic [3:0]          slot,
  input  logic signed [31:0]  x_pos,
  input  logic signed [31:0]  y_pos,
  input  logic [14:0]         view_left,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [GSLOT_W-1:0]  granted_slot,
  output logic                granted,
  output logic                visible,
  output logic                retired,
  output logic [RECL_W-1:0]   reclaimed,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  opfl_cmd_t cmd;  // controller commands
  opfl_sts_t sts;  // datapath status

  opfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  opfl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind),
    .slot         (slot),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .view_left    (view_left),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .granted_slot (granted_slot),
    .granted      (granted),
    .visible      (visible),
    .retired      (retired),
    .reclaimed    (reclaimed)
  );

endmodule

### rtl/opfl_chk.sv
// ----------------------------------------------------------------------------
// opfl_chk
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module opfl_chk import opfl_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [GSLOT_W-1:0] granted_slot,
  input logic               granted,
  input logic               visible,
  input logic               retired,
  input logic [RECL_W-1:0]  reclaimed
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted_slot) &&
      $stable(granted) && $stable(visible) && $stable(retired) &&
      $stable(reclaimed))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_grant_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |-> !visible && !retired && reclaimed == '0)
    else $error("grant mixed with other result fields");

  a_vis_ret: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(visible && retired))
    else $error("object both visible and retired");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> granted_slot == '0)
    else $error("slot reported without grant");

endmodule

bind object_pool_free_list_allocator_top opfl_chk u_opfl_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .granted_slot (granted_slot),
  .granted      (granted),
  .visible      (visible),
  .retired      (retired),
  .reclaimed    (reclaimed)
);

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives spawn, position-report, sweep and unused-kind items into the object
// pool allocator under several register settings and handshake stall
// patterns. A cycle-free model of the free and active lists predicts every
// result, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import opfl_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before giving up
  localparam int SETTLE_CYCLES = 24;    // longer than a full-list sweep
  localparam int PHASE_ITEMS   = 275;

  // Directed report geometry at the reset register values
  localparam int DIR_LEFT  = 100;
  localparam int DIR_LO    = (DIR_LEFT - int'(RST_OBJ_W)) * 65536;
  localparam int DIR_HI    = (DIR_LEFT + int'(RST_VIEW_W)) * 65536;
  localparam int DIR_TOP   = -(int'(RST_OBJ_H) * 65536);
  localparam int DIR_BOT   = int'(RST_FIELD_H) * 65536 - 1;

  typedef struct {
    logic [1:0]         kind;
    logic [3:0]         slot;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [14:0]        left;
  } pool_op_t;

  typedef struct packed {
    logic [GSLOT_W-1:0] gslot;
    logic               gran;
    logic               vis;
    logic               ret;
    logic [RECL_W-1:0]  recl;
  } pool_outcome_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          kind = '0;
  logic [3:0]          slot = '0;
  logic signed [31:0]  x_pos = '0;
  logic signed [31:0]  y_pos = '0;
  logic [14:0]         view_left = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [GSLOT_W-1:0]  granted_slot;
  logic                granted;
  logic                visible;
  logic                retired;
  logic [RECL_W-1:0]   reclaimed;
  logic                cfg_we = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  object_pool_free_list_allocator_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .slot         (slot),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .view_left    (view_left),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .granted_slot (granted_slot),
    .granted      (granted),
    .visible      (visible),
    .retired      (retired),
    .reclaimed    (reclaimed),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Pool model: own copy of the lists, flags and registers
  // --------------------------------------------------------------------------
  logic [PTR_W-1:0] link_tbl [SLOTS];
  bit               obj_live [SLOTS];
  bit               obj_seen [SLOTS];
  logic [PTR_W-1:0] free_top;
  logic [PTR_W-1:0] active_top;

  logic [7:0] cfg_obj_w;
  logic [7:0] cfg_obj_h;
  logic [9:0] cfg_field_h;
  logic [9:0] cfg_view_w;

  pool_op_t      op_queue [$];       // items waiting for the driver
  pool_outcome_t pool_outcomes [$];  // results owed by the block, oldest first

  int  ops_issued  = 0;
  int  ops_taken   = 0;
  int  fault_count = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  in_fired    = 1'b0;
  bit  out_fired   = 1'b0;
  int  idle_cycles = 0;

  pool_op_t      taken_op;
  pool_op_t      next_op;
  pool_outcome_t due;

  function automatic void reset_pool();
    for (int i = 0; i < SLOTS; i++) begin
      link_tbl[i] = (i + 1 < SLOTS) ? PTR_W'(i + 1) : NIL;
      obj_live[i] = 1'b0;
      obj_seen[i] = 1'b0;
    end
    free_top    = '0;
    active_top  = NIL;
    cfg_obj_w   = RST_OBJ_W;
    cfg_obj_h   = RST_OBJ_H;
    cfg_field_h = RST_FIELD_H;
    cfg_view_w  = RST_VIEW_W;
  endfunction

  // Applies one item to the model and returns the result it owes.
  function automatic pool_outcome_t apply_pool_op(pool_op_t op);
    pool_outcome_t    res;
    logic [PTR_W-1:0] s;
    logic [PTR_W-1:0] prev;
    logic [PTR_W-1:0] cur;
    logic [PTR_W-1:0] nxt;
    longint           xv, yv, lft, top_edge, bot_edge, left_edge, right_edge;
    logic             outside;
    int               count;
    res = '0;
    case (op.kind)
      KIND_SPAWN: begin
        // pop free head, push onto active head; empty pool grants nothing
        if (free_top < SLOTS) begin
          s = free_top;
          free_top = link_tbl[s[SLOT_W-1:0]];
          link_tbl[s[SLOT_W-1:0]] = active_top;
          active_top = s;
          obj_live[s[SLOT_W-1:0]] = 1'b1;
          obj_seen[s[SLOT_W-1:0]] = 1'b0;
          res.gslot = s[GSLOT_W-1:0];
          res.gran = 1'b1;
        end
      end
      KIND_REPORT: begin
        // free or dead slots are ignored
        if (obj_live[op.slot]) begin
          xv = op.x;
          yv = op.y;
          lft = op.left;
          top_edge = cfg_obj_h;
          top_edge = -(top_edge * 65536);
          bot_edge = cfg_field_h;
          bot_edge = bot_edge * 65536 - 1;
          left_edge = cfg_obj_w;
          left_edge = (lft - left_edge) * 65536;
          right_edge = cfg_view_w;
          right_edge = (lft + right_edge) * 65536;
          outside = (yv < top_edge) || (yv > bot_edge) ||
                    (xv < left_edge) || (xv > right_edge);
          if (outside) begin
            // only an object that was on screen once can die
            if (obj_seen[op.slot]) begin
              obj_live[op.slot] = 1'b0;
              res.ret = 1'b1;
            end
          end else begin
            obj_seen[op.slot] = 1'b1;
            res.vis = 1'b1;
          end
        end
      end
      KIND_SWEEP: begin
        // walk the active list, move dead slots to the free head in walk order
        prev = NIL;
        cur = active_top;
        count = 0;
        for (int g = 0; g < SLOTS && cur < SLOTS; g++) begin
          nxt = link_tbl[cur[SLOT_W-1:0]];
          if (!obj_live[cur[SLOT_W-1:0]]) begin
            if (prev < SLOTS) link_tbl[prev[SLOT_W-1:0]] = nxt;
            else active_top = nxt;
            link_tbl[cur[SLOT_W-1:0]] = free_top;
            free_top = cur;
            count++;
          end else begin
            prev = cur;
          end
          cur = nxt;
        end
        res.recl = RECL_W'(count);
      end
      default: ;  // unused kind: no state change, all zero
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: register writes, input transfers and result checks at the
  // rising edge. Flags are blocking so the driver sees them at the next
  // falling edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fired  = in_valid && in_ready;
    out_fired = out_valid && out_ready;
    if (rst) begin
      reset_pool();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OBJ_W:   cfg_obj_w   = cfg_data[7:0];
          REG_OBJ_H:   cfg_obj_h   = cfg_data[7:0];
          REG_FIELD_H: cfg_field_h = cfg_data[9:0];
          REG_VIEW_W:  cfg_view_w  = cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_fired) begin
        taken_op.kind = kind;
        taken_op.slot = slot;
        taken_op.x    = x_pos;
        taken_op.y    = y_pos;
        taken_op.left = view_left;
        pool_outcomes.push_back(apply_pool_op(taken_op));
        ops_taken++;
      end
      if (out_fired) begin
        if (pool_outcomes.size() == 0) begin
          $error("result with nothing outstanding");
          fault_count++;
        end else begin
          due = pool_outcomes.pop_front();
          if (granted_slot !== due.gslot) begin
            $error("granted_slot: expected %0d, actual %0d", due.gslot, granted_slot);
            fault_count++;
          end
          if (granted !== due.gran) begin
            $error("granted: expected %0d, actual %0d", due.gran, granted);
            fault_count++;
          end
          if (visible !== due.vis) begin
            $error("visible: expected %0d, actual %0d", due.vis, visible);
            fault_count++;
          end
          if (retired !== due.ret) begin
            $error("retired: expected %0d, actual %0d", due.ret, retired);
            fault_count++;
          end
          if (reclaimed !== due.recl) begin
            $error("reclaimed: expected %0d, actual %0d", due.recl, reclaimed);
            fault_count++;
          end
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("object_pool_free_list_allocator_top test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: new item after a transfer or from idle, with random gaps.
  // Receiver stalls are rolled every cycle. Both change at the falling edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (op_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_op = op_queue.pop_front();
        in_valid  <= 1'b1;
        kind      <= next_op.kind;
        slot      <= next_op.slot;
        x_pos     <= next_op.x;
        y_pos     <= next_op.y;
        view_left <= next_op.left;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_op(input logic [1:0] k, input logic [3:0] s,
                         input logic signed [31:0] x, input logic signed [31:0] y,
                         input logic [14:0] l);
    pool_op_t op;
    op.kind = k;
    op.slot = s;
    op.x    = x;
    op.y    = y;
    op.left = l;
    op_queue.push_back(op);
    ops_issued++;
  endtask

  // Held for one cycle, then released for one so back-to-back writes never
  // raise and lower the enable in the same step.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Narrow registers get random junk in the unused upper data bits.
  task automatic set_config(input int ow, input int oh, input int fh, input int vw);
    write_reg(REG_OBJ_W,   {2'($urandom_range(3)), 8'(ow)});
    write_reg(REG_OBJ_H,   {2'($urandom_range(3)), 8'(oh)});
    write_reg(REG_FIELD_H, 10'(fh));
    write_reg(REG_VIEW_W,  10'(vw));
  endtask

  // Waits for every item to be taken and every result to arrive, then lets
  // the block settle.
  task automatic wait_drained();
    while (ops_taken != ops_issued || pool_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Coordinate biased toward the cull edges: inside, exactly on an edge,
  // one LSB past an edge, or anywhere.
  function automatic logic signed [31:0] pick_coord(input longint lo, input longint hi);
    longint             v;
    longint             r;
    logic signed [31:0] raw;
    int                 roll;
    roll = $urandom_range(99);
    if (roll < 40) begin
      r = $urandom;
      v = lo + (r % (hi - lo + 1));
    end else if (roll < 50) v = lo;
    else if (roll < 60) v = hi;
    else if (roll < 65) v = lo - 1;
    else if (roll < 70) v = hi + 1;
    else begin
      raw = $urandom;
      v = raw;
    end
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Mostly spawns and reports on live slots near the edges, some sweeps,
  // a little unused-kind noise. Items go out one or two ahead so the live
  // set is close to current.
  task automatic run_phase(input int count, input int tx_pct, input int rx_pct);
    int                 roll;
    logic [1:0]         k;
    logic [3:0]         s;
    logic signed [31:0] x, y;
    logic [14:0]        l;
    longint             lft, lo, hi, top_edge, bot_edge;
    int                 ids[$];
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      while (op_queue.size() >= 2) @(negedge clk);
      roll = $urandom_range(99);
      s = 4'($urandom_range(15));
      x = $urandom;
      y = $urandom;
      l = 15'($urandom_range(32767));
      if (roll < 30) k = KIND_SPAWN;
      else if (roll < 85) k = KIND_REPORT;
      else if (roll < 95) k = KIND_SWEEP;
      else k = KIND_UNUSED;
      if (k == KIND_REPORT) begin
        ids.delete();
        for (int i = 0; i < SLOTS; i++) if (obj_live[i]) ids.push_back(i);
        if (ids.size() != 0 && $urandom_range(3) != 0)
          s = 4'(ids[$urandom_range(ids.size() - 1)]);
        if ($urandom_range(4) != 0) l = 15'($urandom_range(2000));
        lft = l;
        lo = cfg_obj_w;
        lo = (lft - lo) * 65536;
        hi = cfg_view_w;
        hi = (lft + hi) * 65536;
        top_edge = cfg_obj_h;
        top_edge = -(top_edge * 65536);
        bot_edge = cfg_field_h;
        bot_edge = bot_edge * 65536 - 1;
        x = pick_coord(lo, hi);
        y = pick_coord(top_edge, bot_edge);
      end
      push_op(k, s, x, y, l);
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset register values, sender and receiver both stalling
    tx_idle_pct = 26;
    rx_idle_pct = 49;
    push_op(KIND_UNUSED, 4'hf, -32'sd1, 32'sh8000_0000, 15'h7fff);   // no-op
    push_op(KIND_REPORT, 4'd0, 32'sd0, 32'sd0, 15'(DIR_LEFT));       // free slot
    push_op(KIND_SWEEP, '0, '0, '0, '0);                              // empty list
    repeat (SLOTS + 1) push_op(KIND_SPAWN, '0, '0, '0, '0);           // last: pool empty
    // corners of the view, exactly on the edges: visible
    push_op(KIND_REPORT, 4'd15, DIR_LO, DIR_TOP, 15'(DIR_LEFT));
    push_op(KIND_REPORT, 4'd14, DIR_HI, DIR_BOT, 15'(DIR_LEFT));
    // far right of the world with the viewport at its maximum
    push_op(KIND_REPORT, 4'd13, 32'sh7fff_ffff, 32'sd0, 15'h7fff);
    // outside but never seen: no change
    push_op(KIND_REPORT, 4'd12, 32'sh8000_0000, 32'sd0, 15'(DIR_LEFT));
    // one LSB past the left, top and right edges after being seen: retired
    push_op(KIND_REPORT, 4'd15, DIR_LO - 1, 32'sd0, 15'(DIR_LEFT));
    push_op(KIND_REPORT, 4'd14, DIR_HI, DIR_TOP - 1, 15'(DIR_LEFT));
    push_op(KIND_REPORT, 4'd13, DIR_HI + 1, 32'sd0, 15'(DIR_LEFT));
    // dead, waiting for a sweep: ignored
    push_op(KIND_REPORT, 4'd15, DIR_LO, 32'sd0, 15'(DIR_LEFT));
    push_op(KIND_SWEEP, '0, '0, '0, '0);
    wait_drained();

    // Random phases over register settings and stall patterns
    run_phase(PHASE_ITEMS, 26, 49);
    set_config(1, 1, 1, 1);
    run_phase(PHASE_ITEMS, 26, 49);
    set_config(255, 255, 1023, 1023);
    run_phase(PHASE_ITEMS, 49, 26);
    set_config($urandom_range(1, 255), $urandom_range(1, 255),
               $urandom_range(1, 1023), $urandom_range(1, 1023));
    run_phase(PHASE_ITEMS, 49, 26);
    set_config($urandom_range(1, 255), $urandom_range(1, 255),
               $urandom_range(1, 1023), $urandom_range(1, 1023));
    run_phase(PHASE_ITEMS, 0, 0);
    set_config(int'(RST_OBJ_W), int'(RST_OBJ_H), int'(RST_FIELD_H), int'(RST_VIEW_W));
    run_phase(PHASE_ITEMS, 0, 0);

    // catch any stray result
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fault_count == 0 && pool_outcomes.size() == 0) begin
      $display("object_pool_free_list_allocator_top test passed");
    end else begin
      if (pool_outcomes.size() != 0)
        $error("%0d results never arrived", pool_outcomes.size());
      $display("object_pool_free_list_allocator_top test failed");
    end
    $finish;
  end

endmodule
